### sv/sfr_pkg.sv
// Shared types and constants for the SOH/STX framed byte receiver.
package sfr_pkg;

	localparam logic [7:0] CH_SOH = 8'h01;
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_EOT = 8'h04;

	localparam logic [15:0] MAX_LEN_RESET = 16'd255;

	typedef enum logic [2:0] {
		ST_NONE     = 3'd0,
		ST_GOOD     = 3'd1,
		ST_NO_STX   = 3'd2,
		ST_TOO_LONG = 3'd3,
		ST_NO_ETX   = 3'd4,
		ST_BAD_LRC  = 3'd5,
		ST_NO_EOT   = 3'd6
	} frame_status_t;

	typedef struct packed {
		logic          payload_valid;
		logic [7:0]    payload_byte;
		frame_status_t frame_status;
		logic [15:0]   frame_length;
	} result_t;

endpackage

### sv/sfr_parser.sv
// Frame parse state, length/count/sum tracking and per-byte result logic.
module sfr_parser import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        byte_accept,
	input  logic [7:0]  rx_byte,
	output result_t     result
);

	typedef enum logic [2:0] {
		PS_HUNT    = 3'd0,
		PS_LEN_LO  = 3'd1,
		PS_LEN_HI  = 3'd2,
		PS_STX     = 3'd3,
		PS_PAYLOAD = 3'd4,
		PS_ETX     = 3'd5,
		PS_LRC     = 3'd6,
		PS_EOT     = 3'd7
	} parse_state_t;

	parse_state_t state_q, state_d;
	logic [15:0]  max_len_q;
	logic [15:0]  decl_len_q, decl_len_d;
	logic [15:0]  count_q, count_d;
	logic [7:0]   sum_q, sum_d;
	logic [7:0]   lrc_expect;
	frame_status_t status;

	assign lrc_expect = (~sum_q) + 8'd1;

	always_comb begin
		state_d    = state_q;
		decl_len_d = decl_len_q;
		count_d    = count_q;
		sum_d      = sum_q;
		status     = ST_NONE;
		result.payload_valid = 1'b0;
		result.payload_byte  = 8'd0;
		case (state_q)
			PS_HUNT: begin
				if (rx_byte == CH_SOH)
					state_d = PS_LEN_LO;
			end
			PS_LEN_LO: begin
				decl_len_d = {8'd0, rx_byte};
				count_d    = 16'd0;
				sum_d      = 8'd0;
				state_d    = PS_LEN_HI;
			end
			PS_LEN_HI: begin
				decl_len_d = {rx_byte, decl_len_q[7:0]};
				state_d    = PS_STX;
			end
			PS_STX: begin
				if (rx_byte == CH_STX) begin
					state_d = (decl_len_q != 16'd0) ? PS_PAYLOAD : PS_ETX;
				end else begin
					status  = ST_NO_STX;
					state_d = PS_HUNT;
				end
			end
			PS_PAYLOAD: begin
				if (count_q >= max_len_q) begin
					status  = ST_TOO_LONG;
					state_d = PS_HUNT;
				end else begin
					result.payload_valid = 1'b1;
					result.payload_byte  = rx_byte;
					sum_d   = sum_q + rx_byte;
					// count_q < max_len_q, so this cannot wrap
					count_d = count_q + 16'd1;
					if (count_d >= decl_len_q)
						state_d = PS_ETX;
				end
			end
			PS_ETX: begin
				if (rx_byte == CH_ETX) begin
					state_d = PS_LRC;
				end else begin
					status  = ST_NO_ETX;
					state_d = PS_HUNT;
				end
			end
			PS_LRC: begin
				if (rx_byte == lrc_expect) begin
					state_d = PS_EOT;
				end else begin
					status  = ST_BAD_LRC;
					state_d = PS_HUNT;
				end
			end
			PS_EOT: begin
				status  = (rx_byte == CH_EOT) ? ST_GOOD : ST_NO_EOT;
				state_d = PS_HUNT;
			end
			default: begin
				state_d = PS_HUNT;
			end
		endcase
		result.frame_status = status;
		result.frame_length = (status != ST_NONE) ? decl_len_q : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= PS_HUNT;
			max_len_q  <= MAX_LEN_RESET;
			decl_len_q <= 16'd0;
			count_q    <= 16'd0;
			sum_q      <= 8'd0;
		end else begin
			if (cfg_wr_en)
				max_len_q <= cfg_wr_data;
			if (byte_accept) begin
				state_q    <= state_d;
				decl_len_q <= decl_len_d;
				count_q    <= count_d;
				sum_q      <= sum_d;
			end
		end
	end

endmodule

### sv/sfr_skid.sv
// Result register with a skid entry so one more input is taken under output stall.
module sfr_skid import sfr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    take;
	logic    accept;

	assign in_stall  = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;
	assign take      = main_valid_q && !out_stall;
	assign accept    = in_valid && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					main_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (accept) begin
				if (!main_valid_q || take)
					main_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end else if (take) begin
				main_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take)
				main_q <= skid_q;
		end else if (accept) begin
			if (!main_valid_q || take)
				main_q <= in_data;
			else
				skid_q <= in_data;
		end
	end

endmodule

### sv/soh_stx_frame_receiver_lrc.sv
// Top level of the SOH/STX framed byte receiver with LRC check.
// Parses SOH, length lo, length hi, STX, payload, ETX, LRC, EOT from one byte
// per input beat and gives exactly one result beat per input beat: a payload
// byte as it passes, a frame verdict with the declared length when the frame
// ends or is dropped, or neither. One byte is taken every cycle unless in_stall
// is high; each result is registered in the result register, under stall in
// the skid entry first. The two-entry output stage (result register plus skid
// entry) takes one more byte while the output is stalled. max_payload_length
// resets to 255 and may be rewritten through cfg_wr_en/cfg_wr_data while idle.
module soh_stx_frame_receiver_lrc import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        payload_valid,
	output logic [7:0]  payload_byte,
	output logic [2:0]  frame_status,
	output logic [15:0] frame_length
);

	result_t parse_res;
	result_t out_res;
	logic    byte_accept;

	assign byte_accept = in_valid && !in_stall;

	sfr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.byte_accept (byte_accept),
		.rx_byte     (rx_byte),
		.result      (parse_res)
	);

	sfr_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (parse_res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign payload_valid = out_res.payload_valid;
	assign payload_byte  = out_res.payload_byte;
	assign frame_status  = out_res.frame_status;
	assign frame_length  = out_res.frame_length;

endmodule

### sim/tb_soh_stx_frame_receiver_lrc.sv
// Testbench for the SOH/STX framed byte receiver: random frames, faults, limits and handshake idling.
`timescale 1ns / 1ps

module tb_soh_stx_frame_receiver_lrc;
	import sfr_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int SETTLE_BEATS = 8;
	localparam int PHASE_BYTES  = 68;

	typedef enum logic [2:0] {
		HUNT_SOH, GET_LEN_LO, GET_LEN_HI, GET_STX,
		GET_PAYLOAD, GET_ETX, GET_LRC, GET_EOT
	} rx_phase_t;

	typedef enum int {
		FAULT_NONE, FAULT_STX, FAULT_ETX, FAULT_LRC, FAULT_EOT, FAULT_CUT
	} fault_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = 16'h0000;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte     = 8'h00;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [2:0]  frame_status;
	logic [15:0] frame_length;

	soh_stx_frame_receiver_lrc u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.frame_status  (frame_status),
		.frame_length  (frame_length)
	);

	// predictor state
	rx_phase_t   rx_state  = HUNT_SOH;
	logic [15:0] decl_len  = 16'd0;
	logic [15:0] pay_count = 16'd0;
	logic [7:0]  run_sum   = 8'd0;
	logic [15:0] len_limit = MAX_LEN_RESET;

	logic [7:0] tx_bytes[$];
	result_t    expected_results[$];
	logic       in_fire     = 1'b0;
	bit         idle_on     = 1'b1;
	int         send_gap    = 0;
	int         stall_left  = 0;
	int         errors      = 0;
	int         frame_bytes = 0;
	int         cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic result_t predict_beat(input logic [7:0] b);
		result_t    r;
		logic [7:0] lrc;
		r = '0;
		r.frame_status = ST_NONE;
		case (rx_state)
			HUNT_SOH: begin
				if (b == CH_SOH) rx_state = GET_LEN_LO;
			end
			GET_LEN_LO: begin
				decl_len  = {8'h00, b};
				pay_count = 16'd0;
				run_sum   = 8'd0;
				rx_state  = GET_LEN_HI;
			end
			GET_LEN_HI: begin
				decl_len[15:8] = b;
				rx_state       = GET_STX;
			end
			GET_STX: begin
				if (b == CH_STX) begin
					rx_state = (decl_len != 16'd0) ? GET_PAYLOAD : GET_ETX;
				end else begin
					r.frame_status = ST_NO_STX;
					rx_state       = HUNT_SOH;
				end
			end
			GET_PAYLOAD: begin
				if (pay_count >= len_limit) begin
					r.frame_status = ST_TOO_LONG;
					rx_state       = HUNT_SOH;
				end else begin
					r.payload_valid = 1'b1;
					r.payload_byte  = b;
					run_sum         = run_sum + b;
					pay_count       = pay_count + 16'd1;
					if (pay_count >= decl_len) rx_state = GET_ETX;
				end
			end
			GET_ETX: begin
				if (b == CH_ETX) begin
					rx_state = GET_LRC;
				end else begin
					r.frame_status = ST_NO_ETX;
					rx_state       = HUNT_SOH;
				end
			end
			GET_LRC: begin
				lrc = ~run_sum + 8'd1;
				if (b == lrc) begin
					rx_state = GET_EOT;
				end else begin
					r.frame_status = ST_BAD_LRC;
					rx_state       = HUNT_SOH;
				end
			end
			default: begin
				r.frame_status = (b == CH_EOT) ? ST_GOOD : ST_NO_EOT;
				rx_state       = HUNT_SOH;
			end
		endcase
		if (r.frame_status != ST_NONE) r.frame_length = decl_len;
		return r;
	endfunction

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap--;
			end else if (tx_bytes.size() == 0) begin
				in_valid <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				send_gap = $urandom_range(0, 6);
			end else begin
				in_valid <= 1'b1;
				rx_byte  <= tx_bytes.pop_front();
			end
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		if (!idle_on || !arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 9) == 0) begin
			out_stall  <= 1'b1;
			stall_left = $urandom_range(0, 6);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// accepted input beats feed the predictor; accepted output beats are checked
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall) expected_results.push_back(predict_beat(rx_byte));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat: valid=%0b byte=%h status=%0d len=%0d",
						$time, payload_valid, payload_byte, frame_status, frame_length);
				end else begin
					want = expected_results.pop_front();
					if (payload_valid !== want.payload_valid ||
					    payload_byte !== want.payload_byte ||
					    frame_status !== want.frame_status ||
					    frame_length !== want.frame_length) begin
						errors++;
						$display("%0t: mismatch: expected valid=%0b byte=%h status=%0d len=%0d",
							$time, want.payload_valid, want.payload_byte,
							want.frame_status, want.frame_length);
						$display("%0t:           actual valid=%0b byte=%h status=%0d len=%0d",
							$time, payload_valid, payload_byte, frame_status, frame_length);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] wrong_byte(input logic [7:0] good);
		logic [7:0] w;
		// SOH in a bad spot must not restart the frame
		w = ($urandom_range(0, 3) == 0) ? CH_SOH : 8'($urandom);
		if (w == good) w = good ^ 8'h80;
		return w;
	endfunction

	function automatic logic [7:0] payload_value();
		return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
	endfunction

	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (len_limit < 16'd64 && r == 0) return 16'($urandom);
		if (r < 3) return 16'($urandom_range(9, 40));
		return 16'($urandom_range(0, 8));
	endfunction

	task automatic queue_frame(input logic [15:0] len, input fault_t fault);
		logic [7:0] frame[$];
		logic [7:0] b;
		logic [7:0] sum;
		logic [7:0] lrc;
		int         n_pay;
		n_pay = (int'(len) > int'(len_limit)) ? int'(len_limit) + 1 : int'(len);
		frame = {CH_SOH, len[7:0], len[15:8],
			(fault == FAULT_STX) ? wrong_byte(CH_STX) : CH_STX};
		sum = 8'd0;
		for (int i = 0; i < n_pay; i++) begin
			b = payload_value();
			frame.push_back(b);
			sum = sum + b;
		end
		// an over-long frame dies on its extra payload beat, no trailer follows
		if (int'(len) <= int'(len_limit)) begin
			lrc = ~sum + 8'd1;
			frame.push_back((fault == FAULT_ETX) ? wrong_byte(CH_ETX) : CH_ETX);
			frame.push_back((fault == FAULT_LRC) ? wrong_byte(lrc) : lrc);
			frame.push_back((fault == FAULT_EOT) ? wrong_byte(CH_EOT) : CH_EOT);
		end
		if (fault == FAULT_CUT) frame = frame[0:$urandom_range(0, frame.size() - 2)];
		frame_bytes += frame.size();
		foreach (frame[i]) tx_bytes.push_back(frame[i]);
	endtask

	task automatic queue_random_traffic(input int n_bytes);
		int     start;
		fault_t f;
		start = frame_bytes;
		while (frame_bytes - start < n_bytes) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3)) tx_bytes.push_back(8'($urandom));
			end else begin
				f = ($urandom_range(0, 9) < 6) ? FAULT_NONE : fault_t'($urandom_range(1, 5));
				queue_frame(pick_length(), f);
			end
		end
		// queue a frame cut short in its payload so the next limit can land mid-frame
		tx_bytes = {tx_bytes, CH_SOH, 8'd6, 8'd0, CH_STX, payload_value(), payload_value()};
	endtask

	task automatic wait_drained();
		while (tx_bytes.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		len_limit = v;
	endtask

	initial begin
		logic [15:0] limits[$];
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset limit: ignored bytes, a two-byte good frame, an empty frame, SOH in place of STX
		tx_bytes = {8'h00, 8'hff,
			CH_SOH, 8'd2, 8'd0, CH_STX, 8'h00, 8'hff, CH_ETX, 8'h01, CH_EOT,
			CH_SOH, 8'd0, 8'd0, CH_STX, CH_ETX, 8'h00, CH_EOT,
			CH_SOH, 8'd1, 8'd0, CH_SOH, 8'h00};
		@(negedge clk);
		wait_drained();

		limits = {16'd0, 16'hffff, 16'($urandom_range(1, 6)), MAX_LEN_RESET, 16'($urandom)};
		foreach (limits[i]) begin
			idle_on = ($urandom_range(0, 3) != 0);
			write_limit(limits[i]);
			queue_random_traffic(PHASE_BYTES);
			@(negedge clk);
			wait_drained();
		end

		// closing stretch at full rate
		idle_on = 1'b0;
		write_limit(16'($urandom_range(2, 10)));
		queue_random_traffic(PHASE_BYTES);
		@(negedge clk);
		wait_drained();
		repeat (SETTLE_BEATS) @(negedge clk);

		if (errors == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
